>>> sv/tes_pkg.sv
package tes_pkg;

    localparam int DATA_BITS = 16;
    localparam int LEN_BITS  = 8;
    localparam int STEP_BITS = 3;
    localparam int ADDR_BITS = 2;

    localparam logic OP_MEASURE   = 1'b0;
    localparam logic OP_CALIBRATE = 1'b1;

    localparam logic [ADDR_BITS-1:0] REG_THRESHOLD_FIRST  = 2'd0;
    localparam logic [ADDR_BITS-1:0] REG_THRESHOLD_SECOND = 2'd1;
    localparam logic [ADDR_BITS-1:0] REG_SLIDER_STEPS     = 2'd2;

    localparam logic [DATA_BITS-1:0] THRESHOLD_RESET = 16'd100;
    localparam logic [LEN_BITS-1:0]  LENGTH_RESET    = 8'd40;

    typedef struct packed {
        logic sub;
    } alu_op_t;

    typedef struct packed {
        logic                 next_electrode;
        logic [DATA_BITS-1:0] electrode_delta;
        logic                 pair_done;
        logic [LEN_BITS-1:0]  position;
    } result_t;

endpackage

>>> sv/tes_alu.sv
module tes_alu #(
    parameter int WIDTH = 24
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  tes_pkg::alu_op_t op,
    output logic [WIDTH-1:0] y,
    output logic             neg
);

    logic [WIDTH:0] full;

    assign full = {1'b0, a} + ({1'b0, b} ^ {(WIDTH + 1){op.sub}}) + (WIDTH + 1)'(op.sub);
    assign y    = full[WIDTH-1:0];
    assign neg  = full[WIDTH];

endmodule

>>> sv/tes_core.sv
module tes_core #(
    parameter int COUNT_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [COUNT_BITS-1:0]             count,
    input  logic                              opcode,
    input  logic [tes_pkg::DATA_BITS-1:0]     threshold_first,
    input  logic [tes_pkg::DATA_BITS-1:0]     threshold_second,
    input  logic [tes_pkg::LEN_BITS-1:0]      slider_steps,
    output logic                              res_valid,
    input  logic                              res_ready,
    output tes_pkg::result_t                  res
);

    localparam int SUM_BITS  = COUNT_BITS + 1;
    localparam int PROD_BITS = COUNT_BITS + tes_pkg::LEN_BITS;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [COUNT_BITS-1:0]           baseline_reg [2];
    logic [COUNT_BITS-1:0]           baseline_next [2];
    logic [COUNT_BITS-1:0]           delta_reg [2];
    logic [COUNT_BITS-1:0]           delta_next [2];
    logic                            electrode_reg, electrode_next;
    logic [tes_pkg::LEN_BITS-1:0]    position_reg, position_next;
    logic                            pass_reg, pass_next;
    logic [tes_pkg::STEP_BITS-1:0]   step_reg, step_next;
    logic [PROD_BITS-1:0]            acc_reg, acc_next;
    logic [SUM_BITS-1:0]             sum_reg, sum_next;
    logic [tes_pkg::LEN_BITS-1:0]    quot_reg, quot_next;
    logic [tes_pkg::LEN_BITS-1:0]    share_reg, share_next;
    logic                            next_e_reg, next_e_next;
    logic [COUNT_BITS-1:0]           out_delta_reg, out_delta_next;
    logic                            done_reg, done_next;

    logic [COUNT_BITS-1:0]           base;
    logic [COUNT_BITS-1:0]           delta;
    logic [COUNT_BITS-1:0]           d0;
    logic [COUNT_BITS-1:0]           d1;
    logic                            touch;
    logic [PROD_BITS-1:0]            alu_a;
    logic [PROD_BITS-1:0]            alu_b;
    tes_pkg::alu_op_t                alu_op;
    logic [PROD_BITS-1:0]            alu_y;
    logic                            alu_neg;
    logic [tes_pkg::LEN_BITS-1:0]    quot_fin;
    logic [tes_pkg::LEN_BITS:0]      pos_sum;

    tes_alu #(
        .WIDTH (PROD_BITS)
    ) u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .op  (alu_op),
        .y   (alu_y),
        .neg (alu_neg)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    assign base  = baseline_reg[electrode_reg];
    assign delta = (count > base) ? (count - base) : '0;
    assign d0    = electrode_reg ? delta_reg[0] : delta;
    assign d1    = electrode_reg ? delta : delta_reg[1];
    assign touch = (tes_pkg::DATA_BITS'(d0) > threshold_first)
                || (tes_pkg::DATA_BITS'(d1) > threshold_second);

    assign quot_fin = {quot_reg[tes_pkg::LEN_BITS-2:0], ~alu_neg};
    assign pos_sum  = {1'b0, slider_steps} - {1'b0, share_reg} + {1'b0, quot_fin};

    always_comb
    begin
        alu_op.sub = 1'b0;
        alu_a      = acc_reg << 1;
        alu_b      = slider_steps[step_reg] ? PROD_BITS'(delta_reg[pass_reg]) : '0;
        if (state_reg == ST_DIV)
        begin
            alu_op.sub = 1'b1;
            alu_a      = acc_reg;
            alu_b      = PROD_BITS'(sum_reg) << step_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        baseline_next  = baseline_reg;
        delta_next     = delta_reg;
        electrode_next = electrode_reg;
        position_next  = position_reg;
        pass_next      = pass_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        sum_next       = sum_reg;
        quot_next      = quot_reg;
        share_next     = share_reg;
        next_e_next    = next_e_reg;
        out_delta_next = out_delta_reg;
        done_next      = done_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    electrode_next = ~electrode_reg;
                    next_e_next    = ~electrode_reg;
                    done_next      = 1'b0;
                    state_next     = ST_DONE;
                    if (opcode == tes_pkg::OP_CALIBRATE)
                    begin
                        baseline_next[electrode_reg] = count;
                        out_delta_next               = '0;
                    end
                    else
                    begin
                        delta_next[electrode_reg] = delta;
                        out_delta_next            = delta;
                        if (electrode_reg)
                        begin
                            done_next = 1'b1;
                            sum_next  = {1'b0, d0} + {1'b0, d1};
                            if (touch)
                            begin
                                state_next = ST_MUL;
                                pass_next  = 1'b0;
                                acc_next   = '0;
                                step_next  = '1;
                            end
                            else
                            begin
                                position_next = '0;
                            end
                        end
                    end
                end
            end
            ST_MUL:
            begin
                acc_next  = alu_y;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = ST_DIV;
                    step_next  = '1;
                end
            end
            ST_DIV:
            begin
                if (!alu_neg)
                begin
                    acc_next = alu_y;
                end
                quot_next = quot_fin;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    if (!pass_reg)
                    begin
                        share_next = quot_fin;
                        pass_next  = 1'b1;
                        acc_next   = '0;
                        step_next  = '1;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        position_next = pos_sum[tes_pkg::LEN_BITS:1];
                        state_next    = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            baseline_reg  <= '{default: '0};
            delta_reg     <= '{default: '0};
            electrode_reg <= 1'b0;
            position_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            baseline_reg  <= baseline_next;
            delta_reg     <= delta_next;
            electrode_reg <= electrode_next;
            position_reg  <= position_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pass_reg      <= pass_next;
        step_reg      <= step_next;
        acc_reg       <= acc_next;
        sum_reg       <= sum_next;
        quot_reg      <= quot_next;
        share_reg     <= share_next;
        next_e_reg    <= next_e_next;
        out_delta_reg <= out_delta_next;
        done_reg      <= done_next;
    end

    always_comb
    begin
        res.next_electrode  = next_e_reg;
        res.electrode_delta = tes_pkg::DATA_BITS'(out_delta_reg);
        res.pair_done       = done_reg;
        res.position        = position_reg;
    end

endmodule

>>> sv/two_electrode_touch_slider_top.sv
// channel | handshake            | payload
// s       | s_tvalid / s_tready  | s_tdata: scan_count; s_tuser: opcode
// m       | m_tvalid / m_tready  | m_tdata: next_electrode, electrode_delta, position;
//         |                      | m_tuser: pair_done
// cfg     | cfg_we               | cfg_addr, cfg_wdata
//
// Calibrate or first-electrode item: straight to the result. Second-electrode
// item with touch: two 8-step shift-add multiplies and two 8-step restoring
// divides on one shared adder/subtractor. Without touch: straight to the result.
// Reset clears baselines, deltas, electrode index and position; the
// configuration registers take their default values. The output register lets
// the next item in while a result waits on m_tready.
module two_electrode_touch_slider_top #(
    parameter int COUNT_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // [15:0] scan_count
    input  logic                              s_tuser,   // [0] opcode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,   // [0] next_electrode,
                                                         // [16:1] electrode_delta,
                                                         // [24:17] position, rest 0
    output logic                              m_tuser,   // [0] pair_done
    input  logic                              cfg_we,
    input  logic [tes_pkg::ADDR_BITS-1:0]     cfg_addr,
    input  logic [tes_pkg::DATA_BITS-1:0]     cfg_wdata
);

    logic [tes_pkg::DATA_BITS-1:0] thr_first_reg;
    logic [tes_pkg::DATA_BITS-1:0] thr_second_reg;
    logic [tes_pkg::LEN_BITS-1:0]  length_reg;
    logic                          m_valid_reg, m_valid_next;
    tes_pkg::result_t              m_data_reg, m_data_next;
    logic                          res_valid;
    logic                          res_ready;
    tes_pkg::result_t              res;

    tes_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .count            (s_tdata[COUNT_BITS-1:0]),
        .opcode           (s_tuser),
        .threshold_first  (thr_first_reg),
        .threshold_second (thr_second_reg),
        .slider_steps     (length_reg),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .res              (res)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_first_reg  <= tes_pkg::THRESHOLD_RESET;
            thr_second_reg <= tes_pkg::THRESHOLD_RESET;
            length_reg     <= tes_pkg::LENGTH_RESET;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    tes_pkg::REG_THRESHOLD_FIRST:  thr_first_reg  <= cfg_wdata;
                    tes_pkg::REG_THRESHOLD_SECOND: thr_second_reg <= cfg_wdata;
                    tes_pkg::REG_SLIDER_STEPS:
                        length_reg <= cfg_wdata[tes_pkg::LEN_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_data_reg.position, m_data_reg.electrode_delta,
                       m_data_reg.next_electrode};
    assign m_tuser  = m_data_reg.pair_done;

endmodule
